### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge except while reset is high.
`define ASSERT_CHK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_CHK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/rle_blit_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE blitter package
// Shared constants and the command and status bundles between controller
// and datapath.
// ---------------------------------------------------------------------------
package rle_blit_pkg;

   // Default screen size.
   localparam int DEF_SCREEN_WIDTH  = 320;
   localparam int DEF_SCREEN_HEIGHT = 240;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_X    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_Y    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_W    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_H    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPARENT = 3'd5;
   localparam int CSR_DATA_W = 64;

   // Field widths.
   localparam int CODE_W   = 8;
   localparam int RUN_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int COLOR_W  = 16;
   localparam int COORD_W  = 10;
   localparam int ORIGIN_W = 11;
   localparam int CALC_W   = 13;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // take a request and prepare the run
      logic step;   // lay down one row piece
      logic flush;  // send the held span as the last one of the byte
   } blit_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic final_piece; // current piece ends the run
      logic visible;     // current piece produces a span
      logic pend_valid;  // a span is held back
      logic out_free;    // output register can take a span this cycle
   } blit_sts_type;

endpackage

### rtl/rle_palette_bitmap_blitter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE palette bitmap blitter
// Decodes 2-bit palette run-length bytes into clipped span writes.
// ---------------------------------------------------------------------------
// A request is taken while the block is idle. The controller then spends
// one cycle on each row piece of the run, except while it stalls. The
// number of row pieces is two when the run reaches or crosses the window's
// right edge once, and it goes up to 65 when the width is 1. A flush step
// is added when the final piece and an earlier piece of the byte both
// produce spans, since one span is held back to mark the final one with
// rsp_tlast. A piece step that has to move a span waits while the single
// output register still holds an untaken span. Window writes return the
// cursor to the window origin; write configuration only while the block is
// idle.
module rle_palette_bitmap_blitter #(
   parameter int SCREEN_WIDTH  = rle_blit_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = rle_blit_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [rle_blit_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rle_blit_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rle_blit_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] code_byte
   input  logic                                req_tlast,  // last_of_image
   // Span stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [9:0] span_row, [19:10] span_column, [26:20] span_length,
   // [42:27] span_color, [47:43] zero
   output logic [rle_blit_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                rsp_tlast   // span_last
);
   import rle_blit_pkg::*;

   blit_cmd_type cmd;
   blit_sts_type sts;

   rle_blit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rle_blit_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .code_byte     (req_tdata[CODE_W-1:0]),
      .last_of_image (req_tlast),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

### rtl/rle_blit_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE blitter datapath
// Configuration registers, cursor, run splitting, clipping, one held span
// and the output register.
// ---------------------------------------------------------------------------
module rle_blit_datapath #(
   parameter int SCREEN_WIDTH  = rle_blit_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = rle_blit_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rle_blit_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rle_blit_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [rle_blit_pkg::CODE_W-1:0]      code_byte,
   input  logic                                last_of_image,
   input  rle_blit_pkg::blit_cmd_type           cmd,
   output rle_blit_pkg::blit_sts_type           sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rle_blit_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);
   import rle_blit_pkg::*;

   localparam logic signed [CALC_W-1:0] SW_S = CALC_W'(SCREEN_WIDTH);
   localparam logic signed [CALC_W-1:0] SH_S = CALC_W'(SCREEN_HEIGHT);

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [COUNT_W-1:0] len;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } span_type;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] palette_ff;
   logic [ORIGIN_W-1:0]   win_x_ff;
   logic [ORIGIN_W-1:0]   win_y_ff;
   logic [COORD_W-1:0]    win_w_ff;
   logic [COORD_W-1:0]    win_h_ff;
   logic [COLOR_W-1:0]    transp_ff;

   // Run state.
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               img_last_ff, img_last_in;

   // Held span and output register.
   span_type pend_ff, pend_in;
   logic     pend_valid_ff, pend_valid_in;
   span_type out_ff, out_in;
   logic     out_last_ff, out_last_in;
   logic     out_valid_ff, out_valid_in;

   logic [COORD_W-1:0]  w_eff;
   logic [COORD_W-1:0]  row_inc;
   logic [COORD_W-1:0]  row_next;
   logic [COORD_W:0]    col_sum;
   logic                split;
   logic [COUNT_W-1:0]  piece;
   logic signed [CALC_W-1:0] sy, sx, ex, first_x, last_x, span_len;
   logic                vis;
   logic                win_write;
   span_type            new_span;
   logic [1:0]          pal_sel;

   // Effective width and next-row wrap.
   always_comb begin
      w_eff    = (win_w_ff == '0) ? COORD_W'(1) : win_w_ff;
      row_inc  = cur_row_ff + COORD_W'(1);
      row_next = (row_inc >= win_h_ff) ? '0 : row_inc;
   end

   // Split the run at the window's right edge.
   always_comb begin
      col_sum = {1'b0, cur_col_ff} + (COORD_W+1)'(count_ff);
      split   = (col_sum >= {1'b0, w_eff});
      piece   = split ? COUNT_W'(w_eff - cur_col_ff) : count_ff;
   end

   // Clip the piece to the screen.
   always_comb begin
      sy       = $signed({{(CALC_W-ORIGIN_W){win_y_ff[ORIGIN_W-1]}}, win_y_ff})
                 + $signed({{(CALC_W-COORD_W){1'b0}}, cur_row_ff});
      sx       = $signed({{(CALC_W-ORIGIN_W){win_x_ff[ORIGIN_W-1]}}, win_x_ff})
                 + $signed({{(CALC_W-COORD_W){1'b0}}, cur_col_ff});
      ex       = sx + $signed({{(CALC_W-COUNT_W){1'b0}}, piece});
      first_x  = sx[CALC_W-1] ? '0 : sx;
      last_x   = (ex > SW_S) ? SW_S : ex;
      span_len = last_x - first_x;
      vis      = (piece != '0) && (color_ff != transp_ff)
                 && !sy[CALC_W-1] && (sy < SH_S) && (span_len > 0);
      new_span.row   = sy[COORD_W-1:0];
      new_span.col   = first_x[COORD_W-1:0];
      new_span.len   = span_len[COUNT_W-1:0];
      new_span.color = color_ff;
   end

   // Status toward the controller.
   always_comb begin
      sts.final_piece = !split;
      sts.visible     = vis;
      sts.pend_valid  = pend_valid_ff;
      sts.out_free    = !out_valid_ff || rsp_tready;
   end

   assign win_write = csr_we && ((csr_index == CSR_WINDOW_X) || (csr_index == CSR_WINDOW_Y)
                      || (csr_index == CSR_WINDOW_W) || (csr_index == CSR_WINDOW_H));
   assign pal_sel   = code_byte[CODE_W-1 -: 2];

   // Next state of the run, the held span and the output register.
   always_comb begin
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      count_in      = count_ff;
      color_in      = color_ff;
      img_last_in   = img_last_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;

      if (cmd.load) begin
         count_in    = COUNT_W'(code_byte[RUN_W-1:0]) + COUNT_W'(1);
         color_in    = palette_ff[COLOR_W*pal_sel +: COLOR_W];
         img_last_in = last_of_image;
         // A column left beyond a narrowed window starts a new row.
         if (cur_col_ff >= w_eff) begin
            cur_col_in = '0;
            cur_row_in = row_next;
         end
      end

      if (cmd.step) begin
         // Move spans: the held one goes out once a later one is known.
         if (vis && pend_valid_ff) begin
            out_in        = pend_ff;
            out_last_in   = 1'b0;
            out_valid_in  = 1'b1;
            pend_in       = new_span;
         end else if (vis && split) begin
            pend_in       = new_span;
            pend_valid_in = 1'b1;
         end else if (vis) begin
            out_in        = new_span;
            out_last_in   = 1'b1;
            out_valid_in  = 1'b1;
         end else if (pend_valid_ff && !split) begin
            out_in        = pend_ff;
            out_last_in   = 1'b1;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end
         if (vis && pend_valid_ff) begin
            pend_valid_in = 1'b1;
         end
         // Advance the cursor.
         if (split) begin
            count_in   = count_ff - piece;
            cur_col_in = '0;
            cur_row_in = row_next;
         end else if (img_last_ff) begin
            cur_col_in = '0;
            cur_row_in = '0;
         end else begin
            cur_col_in = col_sum[COORD_W-1:0];
         end
      end

      if (cmd.flush) begin
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (win_write) begin
         cur_col_in = '0;
         cur_row_in = '0;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
         win_x_ff   <= '0;
         win_y_ff   <= '0;
         win_w_ff   <= COORD_W'(1);
         win_h_ff   <= COORD_W'(1);
         transp_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PALETTE:     palette_ff <= csr_wdata;
            CSR_WINDOW_X:    win_x_ff   <= csr_wdata[ORIGIN_W-1:0];
            CSR_WINDOW_Y:    win_y_ff   <= csr_wdata[ORIGIN_W-1:0];
            CSR_WINDOW_W:    win_w_ff   <= csr_wdata[COORD_W-1:0];
            CSR_WINDOW_H:    win_h_ff   <= csr_wdata[COORD_W-1:0];
            CSR_TRANSPARENT: transp_ff  <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      color_ff    <= color_in;
      img_last_ff <= img_last_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-$bits(span_type))'(0), out_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/rle_blit_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RLE blitter controller
// Sequences request intake, one row piece per cycle and the final flush,
// stalling whenever a span has to move and the output register is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rle_blit_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  rle_blit_pkg::blit_sts_type sts,
   output rle_blit_pkg::blit_cmd_type cmd
);
   import rle_blit_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      need_out;
   logic      stall;

   // A piece needs the output register when a span leaves for it.
   always_comb begin
      need_out = (sts.visible && sts.pend_valid)
                 || (sts.final_piece && (sts.visible || sts.pend_valid));
      stall    = need_out && !sts.out_free;
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!stall) begin
               cmd.step = 1'b1;
               if (sts.final_piece) begin
                  state_in = (sts.visible && sts.pend_valid) ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE), "controller not idle after reset")
   `ASSERT_CHK(a_idle_no_pend, (state_ff == ST_IDLE) |-> !sts.pend_valid, "span held while idle")
   `ASSERT_CHK(a_flush_has_pend, (state_ff == ST_FLUSH) |-> sts.pend_valid, "flush with nothing held")
   `ASSERT_CHK(a_load_to_run, cmd.load |=> (state_ff == ST_RUN), "accepted request did not start a run")

endmodule
